/* design/rpst_pkg.sv */
// Package for the range product sign tree block.
// Holds sign class, mode and status codes and the stream field widths.
// No dependencies.
package rpst_pkg;

  localparam int IndexW    = 10;
  localparam int ValueW    = 32;
  localparam int CountW    = 11;
  localparam int InTdataW  = 56;  // first, last, value: 52 bits, padded to bytes
  localparam int OutTdataW = 8;   // sign class, status: 3 bits, padded to a byte

  localparam logic [1:0] CLASS_POS  = 2'd0;
  localparam logic [1:0] CLASS_NEG  = 2'd1;
  localparam logic [1:0] CLASS_ZERO = 2'd2;

  localparam logic MODE_CHANGE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_RANGE = 1'b1;

endpackage

/* design/range_product_sign_tree_top.sv */
// Range product sign tree: top level with the tree sequencer.
// Depends on rpst_pkg and rpst_ram.
//
// The block keeps per-node zero and negative counts of a bottom-up segment tree
// in one RAM (2*MAX_ELEMENTS words) and walks it one node access at a time. A
// change reads the leaf and compares its sign class; if the class changes, it
// writes the leaf and then, for each tree level, reads the sibling and writes
// the parent, up to the root. A change whose index is not below the count is
// dropped in the cycle it is accepted. A query walks the range level by level,
// testing the bounds and reading and adding in the left and right edge nodes,
// one RAM read for each side, then posts the result when the output register
// is free; a bad range is posted directly. One item is in work at a time;
// s_axis_tready_o is high only when the sequencer is idle. After reset a
// clearing pass writes every tree word to zero before the first item is taken.
// Configuration writes are taken in any cycle.
module range_product_sign_tree_top
  import rpst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: element_count.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CountW-1:0]    cfg_data_i,
  // Input items.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: first_index [9:0], last_index [19:10], new_value [51:20], zeros above.
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // tuser: mode [0].
  input  logic                 s_axis_tuser_i,
  // Result items.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata: sign_class [1:0], status [2], zeros above.
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int AW = $clog2(2 * MAX_ELEMENTS);
  localparam int NW = AW + 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int RESET_COUNT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHG_RD = 4'd2;
  localparam logic [3:0] ST_CHG_CK = 4'd3;
  localparam logic [3:0] ST_UP     = 4'd4;
  localparam logic [3:0] ST_SUM    = 4'd5;
  localparam logic [3:0] ST_Q_TEST = 4'd6;
  localparam logic [3:0] ST_Q_LACC = 4'd7;
  localparam logic [3:0] ST_Q_RCHK = 4'd8;
  localparam logic [3:0] ST_Q_RACC = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [NW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     cur_z_q, cur_z_d, cur_n_q, cur_n_d;
  logic [1:0]        new_cls_q, new_cls_d;
  logic [NW-1:0]     l_q, l_d, r_q, r_d;
  logic              any_zero_q, any_zero_d, neg_par_q, neg_par_d;
  logic [1:0]        res_sign_q, res_sign_d;
  logic              res_status_q, res_status_d;
  logic              ovalid_q, ovalid_d;
  logic [1:0]        osign_q, osign_d;
  logic              ostatus_q, ostatus_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [2*CW-1:0]   wdata, rdata;
  logic [CW-1:0]     rd_z, rd_n;
  logic [1:0]        leaf_cls;

  logic [IndexW-1:0] in_first, in_last;
  logic [ValueW-1:0] in_value;
  logic [1:0]        in_cls;
  logic              in_accept, out_free;
  logic [CountW-1:0] cfg_clamped;

  assign in_first = s_axis_tdata_i[IndexW-1:0];
  assign in_last  = s_axis_tdata_i[2*IndexW-1:IndexW];
  assign in_value = s_axis_tdata_i[2*IndexW+ValueW-1:2*IndexW];

  assign in_cls = (in_value == '0) ? CLASS_ZERO :
                  in_value[ValueW-1] ? CLASS_NEG : CLASS_POS;

  assign rd_z = rdata[CW-1:0];
  assign rd_n = rdata[2*CW-1:CW];
  assign leaf_cls = (rd_z != '0) ? CLASS_ZERO :
                    (rd_n != '0) ? CLASS_NEG : CLASS_POS;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !ovalid_q || m_axis_tready_i;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_clamped = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_clamped = CountW'(1);
    end else if (32'(cfg_data_i) > MAX_ELEMENTS) begin
      cfg_clamped = CountW'(MAX_ELEMENTS);
    end
  end

  rpst_ram #(
    .Width(2 * CW),
    .Depth(2 * MAX_ELEMENTS)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    cur_z_d      = cur_z_q;
    cur_n_d      = cur_n_q;
    new_cls_d    = new_cls_q;
    l_d          = l_q;
    r_d          = r_q;
    any_zero_d   = any_zero_q;
    neg_par_d    = neg_par_q;
    res_sign_d   = res_sign_q;
    res_status_d = res_status_q;
    ovalid_d     = ovalid_q && !m_axis_tready_i;
    osign_d      = osign_q;
    ostatus_d    = ostatus_q;
    we           = 1'b0;
    waddr        = cur_q;
    wdata        = '0;
    raddr        = cur_q;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[AW-1:0];
        clr_d = clr_q + NW'(1);
        if (clr_q == NW'(2 * MAX_ELEMENTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser_i == MODE_CHANGE) begin
            cur_d     = AW'(MAX_ELEMENTS) + AW'(in_first);
            new_cls_d = in_cls;
            if (CountW'(in_first) < count_q) begin
              state_d = ST_CHG_RD;
            end
          end else if (in_first > in_last || CountW'(in_last) >= count_q) begin
            res_sign_d   = CLASS_POS;
            res_status_d = STATUS_BAD_RANGE;
            state_d      = ST_DONE;
          end else begin
            l_d          = NW'(MAX_ELEMENTS) + NW'(in_first);
            r_d          = NW'(MAX_ELEMENTS) + NW'(in_last) + NW'(1);
            any_zero_d   = 1'b0;
            neg_par_d    = 1'b0;
            res_status_d = STATUS_OK;
            state_d      = ST_Q_TEST;
          end
        end
      end
      ST_CHG_RD: begin
        raddr   = cur_q;
        state_d = ST_CHG_CK;
      end
      ST_CHG_CK: begin
        if (leaf_cls == new_cls_q) begin
          state_d = ST_IDLE;
        end else begin
          cur_z_d = CW'(new_cls_q == CLASS_ZERO);
          cur_n_d = CW'(new_cls_q == CLASS_NEG);
          we      = 1'b1;
          waddr   = cur_q;
          wdata   = {CW'(new_cls_q == CLASS_NEG), CW'(new_cls_q == CLASS_ZERO)};
          state_d = ST_UP;
        end
      end
      ST_UP: begin
        // Fetch the sibling of the node just written; the root ends the walk.
        raddr = cur_q ^ AW'(1);
        if (cur_q == AW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cur_z_d = cur_z_q + rd_z;
        cur_n_d = cur_n_q + rd_n;
        we      = 1'b1;
        waddr   = cur_q >> 1;
        wdata   = {cur_n_q + rd_n, cur_z_q + rd_z};
        cur_d   = cur_q >> 1;
        state_d = ST_UP;
      end
      ST_Q_TEST: begin
        raddr = l_q[AW-1:0];
        if (l_q >= r_q) begin
          res_sign_d = any_zero_q ? CLASS_ZERO : (neg_par_q ? CLASS_NEG : CLASS_POS);
          state_d    = ST_DONE;
        end else if (l_q[0]) begin
          l_d     = l_q + NW'(1);
          state_d = ST_Q_LACC;
        end else begin
          state_d = ST_Q_RCHK;
        end
      end
      ST_Q_LACC: begin
        any_zero_d = any_zero_q || (rd_z != '0);
        neg_par_d  = neg_par_q ^ rd_n[0];
        state_d    = ST_Q_RCHK;
      end
      ST_Q_RCHK: begin
        raddr = AW'(r_q - NW'(1));
        if (r_q[0]) begin
          r_d     = r_q - NW'(1);
          state_d = ST_Q_RACC;
        end else begin
          l_d     = l_q >> 1;
          r_d     = r_q >> 1;
          state_d = ST_Q_TEST;
        end
      end
      ST_Q_RACC: begin
        any_zero_d = any_zero_q || (rd_z != '0);
        neg_par_d  = neg_par_q ^ rd_n[0];
        l_d        = l_q >> 1;
        r_d        = r_q >> 1;
        state_d    = ST_Q_TEST;
      end
      ST_DONE: begin
        // Wait until the output register is free to take the result.
        if (out_free) begin
          ovalid_d  = 1'b1;
          osign_d   = res_sign_q;
          ostatus_d = res_status_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      count_q  <= CountW'(RESET_COUNT);
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_clamped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    cur_z_q      <= cur_z_d;
    cur_n_q      <= cur_n_d;
    new_cls_q    <= new_cls_d;
    l_q          <= l_d;
    r_q          <= r_d;
    any_zero_q   <= any_zero_d;
    neg_par_q    <= neg_par_d;
    res_sign_q   <= res_sign_d;
    res_status_q <= res_status_d;
    osign_q      <= osign_d;
    ostatus_q    <= ostatus_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - 3){1'b0}}, ostatus_q, osign_q};

endmodule

/* design/rpst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpst_ram #(
  parameter int Width = 22,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* test/range_product_sign_tree_top_test.sv */
// Self-checking testbench for range_product_sign_tree_top: element changes and
// range product sign queries, checked against an in-bench predictor of the array.
// Depends on rpst_pkg and the block's RTL only.
module range_product_sign_tree_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpst_pkg::*;

  localparam int NumElements = 1024;
  localparam int SettleCycles = 64;
  localparam int LongHold = 400;

  typedef struct {
    logic              mode;
    logic [IndexW-1:0] first_idx;
    logic [IndexW-1:0] last_idx;
    logic [ValueW-1:0] value;
    bit                known;
    logic [1:0]        sign;
    logic              status;
  } stim_row_t;

  typedef struct {
    logic [1:0] sign;
    logic       status;
  } sign_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  range_product_sign_tree_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor state: one sign class per element and the active count.
  logic [1:0]        elem_class [NumElements];
  logic [CountW-1:0] elem_count;
  sign_result_t      pending_signs [$];

  int  mismatches = 0;
  int  n_changes = 0;
  int  n_queries = 0;
  int  n_bad_ranges = 0;
  int  n_zero_results = 0;
  int  n_neg_results = 0;
  int  n_settings = 0;
  bit  gaps_on = 1'b1;

  // After reset every element is positive and all 1024 are in use.
  stim_row_t directed_rows [20] = '{
    '{MODE_QUERY,  10'd0,    10'd1023, 32'h0,        1'b1, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd0,    32'h0,        1'b1, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd1023, 10'd1023, 32'h0,        1'b1, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd5,    10'd4,    32'h0,        1'b1, CLASS_POS,  STATUS_BAD_RANGE},
    '{MODE_QUERY,  10'd1023, 10'd0,    32'h0,        1'b1, CLASS_POS,  STATUS_BAD_RANGE},
    '{MODE_CHANGE, 10'd0,    10'd0,    32'h80000000, 1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_CHANGE, 10'd1023, 10'd1023, 32'h7fffffff, 1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_CHANGE, 10'd512,  10'd0,    32'h0,        1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd0,    32'h0,        1'b1, CLASS_NEG,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd1023, 32'h0,        1'b1, CLASS_ZERO, STATUS_OK},
    '{MODE_QUERY,  10'd513,  10'd1023, 32'h0,        1'b1, CLASS_POS,  STATUS_OK},
    '{MODE_CHANGE, 10'd0,    10'd700,  32'hffffffff, 1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd511,  32'h0,        1'b1, CLASS_NEG,  STATUS_OK},
    '{MODE_CHANGE, 10'd512,  10'd0,    32'h1,        1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_CHANGE, 10'd3,    10'd0,    32'hffffffff, 1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd3,    32'h0,        1'b1, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd0,    10'd1023, 32'h0,        1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_CHANGE, 10'd1023, 10'd1023, 32'h80000001, 1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd1,    10'd1023, 32'h0,        1'b0, CLASS_POS,  STATUS_OK},
    '{MODE_QUERY,  10'd4,    10'd1023, 32'h0,        1'b0, CLASS_POS,  STATUS_OK}
  };

  function automatic logic [1:0] class_of_value(logic [ValueW-1:0] v);
    if (v == '0) return CLASS_ZERO;
    if (v[ValueW-1]) return CLASS_NEG;
    return CLASS_POS;
  endfunction

  // Zero wins over everything; otherwise the parity of negatives decides.
  function automatic sign_result_t sign_of_range(logic [IndexW-1:0] lo, logic [IndexW-1:0] hi);
    sign_result_t r;
    bit any_zero;
    bit odd_negs;
    r.sign = CLASS_POS;
    r.status = STATUS_OK;
    any_zero = 1'b0;
    odd_negs = 1'b0;
    if (lo > hi || {1'b0, hi} >= elem_count) begin
      r.status = STATUS_BAD_RANGE;
      return r;
    end
    for (int i = lo; i <= hi; i++) begin
      if (elem_class[i] == CLASS_ZERO) any_zero = 1'b1;
      if (elem_class[i] == CLASS_NEG) odd_negs = ~odd_negs;
    end
    if (any_zero) r.sign = CLASS_ZERO;
    else if (odd_negs) r.sign = CLASS_NEG;
    return r;
  endfunction

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_signs.size());
    $display("TB_ERROR");
    $finish;
  end

  // Result checker: every accepted transaction is matched against the oldest expectation.
  always @(posedge clk_i) begin
    sign_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_signs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got sign %0d status %0d", $time,
                 m_axis_tdata_o[1:0], m_axis_tdata_o[2]);
      end else begin
        exp_r = pending_signs.pop_front();
        if (m_axis_tdata_o[1:0] !== exp_r.sign) begin
          mismatches++;
          $display("%0t: sign class mismatch, expected %0d, got %0d", $time, exp_r.sign,
                   m_axis_tdata_o[1:0]);
        end
        if (m_axis_tdata_o[2] !== exp_r.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time, exp_r.status,
                   m_axis_tdata_o[2]);
        end
        if (exp_r.status == STATUS_BAD_RANGE) n_bad_ranges++;
        else if (exp_r.sign == CLASS_ZERO) n_zero_results++;
        else if (exp_r.sign == CLASS_NEG) n_neg_results++;
      end
    end
  end

  // Result receiver: random stalls, stretches without any, and one long hold-off.
  initial begin
    int taken;
    int stall;
    bit held;
    taken = 0;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i) m_axis_tready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
      stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (taken == 120 && !held) begin
        held = 1'b1;
        stall = LongHold;
      end
      if (stall != 0) begin
        @(negedge clk_i) m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Offers one item and, once it is accepted, updates the predictor.
  task automatic send_item(stim_row_t row);
    int gap;
    sign_result_t r;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= row.mode;
    s_axis_tdata_i  <= {4'b0, row.value, row.last_idx, row.first_idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (row.mode == MODE_QUERY) begin
      n_queries++;
      r = sign_of_range(row.first_idx, row.last_idx);
      if (row.known) begin
        r.sign = row.sign;
        r.status = row.status;
      end
      pending_signs.push_back(r);
    end else begin
      n_changes++;
      if ({1'b0, row.first_idx} < elem_count) elem_class[row.first_idx] = class_of_value(row.value);
    end
  endtask

  // Waits until every expected result has arrived and any trailing change has settled.
  task automatic drain_block();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (pending_signs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_element_count(logic [CountW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    if (v == '0) elem_count = CountW'(1);
    else if (v > NumElements) elem_count = CountW'(NumElements);
    else elem_count = v;
    n_settings++;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    int lo;
    int span;
    row.known = 1'b0;
    row.sign = CLASS_POS;
    row.status = STATUS_OK;
    row.mode = ($urandom_range(0, 99) < 45) ? MODE_QUERY : MODE_CHANGE;
    row.first_idx = IndexW'($urandom_range(0, 1023));
    row.last_idx = IndexW'($urandom_range(0, 1023));
    row.value = $urandom();
    pick = $urandom_range(0, 99);
    if (row.mode == MODE_QUERY) begin
      if (pick < 75) begin
        lo = $urandom_range(0, elem_count - 1);
        span = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
        row.first_idx = IndexW'(lo);
        row.last_idx = IndexW'((lo + span > elem_count - 1) ? elem_count - 1 : lo + span);
      end else if (pick < 88 || elem_count == NumElements) begin
        if (row.first_idx <= row.last_idx && row.first_idx != row.last_idx)
          {row.first_idx, row.last_idx} = {row.last_idx, row.first_idx};
      end else begin
        row.last_idx = IndexW'($urandom_range(elem_count, 1023));
      end
    end else begin
      if (pick < 85) row.first_idx = IndexW'($urandom_range(0, elem_count - 1));
      pick = $urandom_range(0, 99);
      if (pick < 15) row.value = '0;
      else if (pick < 55) row.value[ValueW-1] = 1'b1;
      else if (pick < 95) begin
        row.value[ValueW-1] = 1'b0;
        if (row.value == '0) row.value = 32'h1;
      end else begin
        case ($urandom_range(0, 3))
          0: row.value = 32'h80000000;
          1: row.value = 32'h7fffffff;
          2: row.value = 32'hffffffff;
          default: row.value = 32'h1;
        endcase
      end
    end
    return row;
  endfunction

  initial begin
    logic [CountW-1:0] count_plan [11];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = MODE_CHANGE;
    elem_count = CountW'(NumElements);
    foreach (elem_class[i]) elem_class[i] = CLASS_POS;
    count_plan = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd37, 11'd1025, 11'd1024,
                   11'd0, 11'd0, 11'd1000, 11'd1023};
    count_plan[7] = CountW'($urandom_range(0, 2047));
    count_plan[8] = CountW'($urandom_range(1, 63));
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_block();

    foreach (count_plan[p]) begin
      write_element_count(count_plan[p]);
      gaps_on = (p % 3 != 2);
      for (int i = 0; i < 55; i++) begin
        send_item(random_row());
        // Once, the sender stops and lets every outstanding result come back.
        if (p == 4 && i == 27) drain_block();
      end
      drain_block();
    end

    $display("Covered %0d changes and %0d queries over %0d element count settings.",
             n_changes, n_queries, n_settings);
    $display("Results: %0d bad ranges, %0d zero, %0d negative; %0d mismatches.",
             n_bad_ranges, n_zero_results, n_neg_results, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
